/* src/cmps_pkg.sv */
// Shared types and constants for the compass heading pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package cmps_pkg;

  localparam int RAW_W    = 24;  // raw sample and offset width
  localparam int FIELD_W  = 25;  // corrected field width
  localparam int DECL_W   = 9;   // declination register width
  localparam int HEAD_W   = 9;   // wrapped heading width
  localparam int PRESCALE = 30;  // left shift of |x|, |y| before rotation
  localparam int XY_W     = FIELD_W + PRESCALE + 3;  // rotation gain and sign
  localparam int Z_W      = 25;  // accumulated angle, Q16 degrees, signed
  localparam int ATAN_W   = 22;
  localparam int THETA_W  = 23;  // first-quadrant angle, 0..90 degrees in Q16
  localparam int MAG_W    = 24;  // 0..180 degrees in Q16
  localparam int ANGLE_FRAC = 16;
  localparam int DEG_W    = 10;  // signed whole degrees, -180..180
  localparam int SUM_W    = 11;  // degrees plus declination
  localparam int MAX_STEPS = 32;

  localparam logic [THETA_W-1:0] THETA_90  = 23'd5898240;
  localparam logic [THETA_W-1:0] THETA_45  = 23'd2949120;
  localparam logic [MAG_W-1:0]   HALF_TURN = 24'd11796480;
  localparam logic signed [SUM_W-1:0] FULL_TURN = 11'sd360;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 2'd3;

  // How the first-quadrant angle is found
  typedef enum logic [1:0] {
    THETA_ROTATE = 2'd0,
    THETA_ZERO   = 2'd1,
    THETA_RIGHT  = 2'd2,
    THETA_DIAG   = 2'd3
  } theta_code_t;

  // atan(2^-i) in degrees, Q16, rounded
  localparam logic [ATAN_W-1:0] ATAN_Q16 [0:MAX_STEPS-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0,
    22'd0,       22'd0,       22'd0,      22'd0
  };

  // Fields that ride along with the angle through the rotation stages
  typedef struct packed {
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic                      ok;
    theta_code_t               code;
  } side_t;

endpackage

/* src/cmps_in_if.sv */
// Input channel: one raw magnetometer sample per word, valid/ready handshake.
// Depends on cmps_pkg for field widths.
interface cmps_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [cmps_pkg::RAW_W-1:0]  raw_x;
  logic signed [cmps_pkg::RAW_W-1:0]  raw_y;
  logic signed [cmps_pkg::RAW_W-1:0]  raw_z;
  logic                               sample_ok;

  modport source (output valid, raw_x, raw_y, raw_z, sample_ok, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, sample_ok, output ready);
endinterface

/* src/cmps_out_if.sv */
// Result channel: corrected field and heading per word, valid/ready handshake.
// Depends on cmps_pkg for field widths.
interface cmps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cmps_pkg::FIELD_W-1:0] field_x;
  logic signed [cmps_pkg::FIELD_W-1:0] field_y;
  logic signed [cmps_pkg::FIELD_W-1:0] field_z;
  logic        [cmps_pkg::HEAD_W-1:0]  heading_deg;
  logic                                result_ok;

  modport source (output valid, field_x, field_y, field_z, heading_deg, result_ok,
                  input ready);
  modport sink   (input valid, field_x, field_y, field_z, heading_deg, result_ok,
                  output ready);
endinterface

/* src/compass_heading_from_field.sv */
// Compass heading pipeline: offset correction, vectoring CORDIC, wrap.
// Depends on cmps_pkg, cmps_in_if and cmps_out_if.
//
// Takes one magnetometer word per clock and returns one result word per clock
// while the output is taken. Register stages in order: offset add, magnitude
// and prescale, one register stage per CORDIC rotation, quadrant fold and
// truncation, then the declination add and wrap in the output register. The
// whole pipeline moves together and holds when the output register is full
// and not taken, so a stalled result keeps every word in flight. Heading is
// atan2(y, x) in whole degrees truncated toward zero, plus declination,
// wrapped into 0..360. A failed sample yields an all-zero result word.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait and
// should change only while the pipeline is empty.
module compass_heading_from_field #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  cmps_in_if.sink                            in_ch,
  cmps_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [cmps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmps_pkg::RAW_W-1:0]         cfg_data
);

  localparam int RAW_W   = cmps_pkg::RAW_W;
  localparam int FIELD_W = cmps_pkg::FIELD_W;
  localparam int XY_W    = cmps_pkg::XY_W;
  localparam int Z_W     = cmps_pkg::Z_W;
  localparam int THETA_W = cmps_pkg::THETA_W;
  localparam int MAG_W   = cmps_pkg::MAG_W;
  localparam int DEG_W   = cmps_pkg::DEG_W;
  localparam int SUM_W   = cmps_pkg::SUM_W;
  localparam int DECL_W  = cmps_pkg::DECL_W;
  localparam int HEAD_W  = cmps_pkg::HEAD_W;

  // ---------------- configuration registers
  logic signed [RAW_W-1:0]  off_x_r, off_y_r, off_z_r;
  logic signed [DECL_W-1:0] decl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      decl_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cmps_pkg::CFG_OFFSET_X:    off_x_r <= cfg_data;
        cmps_pkg::CFG_OFFSET_Y:    off_y_r <= cfg_data;
        cmps_pkg::CFG_OFFSET_Z:    off_z_r <= cfg_data;
        cmps_pkg::CFG_DECLINATION: decl_r  <= cfg_data[DECL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline advance
  logic out_v_r;
  logic adv;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 1: offset add
  logic                      s1_v_r;
  logic signed [FIELD_W-1:0] s1_fx_r, s1_fy_r, s1_fz_r;
  logic                      s1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fx_r <= {in_ch.raw_x[RAW_W-1], in_ch.raw_x} + {off_x_r[RAW_W-1], off_x_r};
      s1_fy_r <= {in_ch.raw_y[RAW_W-1], in_ch.raw_y} + {off_y_r[RAW_W-1], off_y_r};
      s1_fz_r <= {in_ch.raw_z[RAW_W-1], in_ch.raw_z} + {off_z_r[RAW_W-1], off_z_r};
      s1_ok_r <= in_ch.sample_ok;
    end
  end

  // ---------------- stage 2: magnitudes, special cases, prescale
  logic [FIELD_W-1:0]    ax, ay;
  cmps_pkg::theta_code_t s1_code;

  assign ax = s1_fx_r[FIELD_W-1] ? FIELD_W'(-s1_fx_r) : FIELD_W'(s1_fx_r);
  assign ay = s1_fy_r[FIELD_W-1] ? FIELD_W'(-s1_fy_r) : FIELD_W'(s1_fy_r);

  always_comb begin
    if (ay == '0) begin
      s1_code = cmps_pkg::THETA_ZERO;
    end else if (ax == '0) begin
      s1_code = cmps_pkg::THETA_RIGHT;
    end else if (ax == ay) begin
      s1_code = cmps_pkg::THETA_DIAG;
    end else begin
      s1_code = cmps_pkg::THETA_ROTATE;
    end
  end

  // Index 0 is the prescaled vector; index k+1 follows rotation k.
  logic                    v_r    [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  x_r    [0:CORDIC_STEPS];
  logic signed [XY_W-1:0]  y_r    [0:CORDIC_STEPS];
  logic signed [Z_W-1:0]   z_r    [0:CORDIC_STEPS];
  cmps_pkg::side_t         side_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]         <= {3'b000, ax, {cmps_pkg::PRESCALE{1'b0}}};
      y_r[0]         <= {3'b000, ay, {cmps_pkg::PRESCALE{1'b0}}};
      z_r[0]         <= '0;
      side_r[0].fx   <= s1_fx_r;
      side_r[0].fy   <= s1_fy_r;
      side_r[0].fz   <= s1_fz_r;
      side_r[0].ok   <= s1_ok_r;
      side_r[0].code <= s1_code;
    end
  end

  // ---------------- CORDIC rotations, one per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  step_ang;

    assign xs       = x_r[k] >>> k;
    assign ys       = y_r[k] >>> k;
    assign step_ang = Z_W'(cmps_pkg::ATAN_Q16[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (adv) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!y_r[k][XY_W-1]) begin
          x_r[k+1] <= x_r[k] + ys;
          y_r[k+1] <= y_r[k] - xs;
          z_r[k+1] <= z_r[k] + step_ang;
        end else begin
          x_r[k+1] <= x_r[k] - ys;
          y_r[k+1] <= y_r[k] + xs;
          z_r[k+1] <= z_r[k] - step_ang;
        end
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // ---------------- quadrant fold and truncation
  cmps_pkg::side_t          fin;
  logic signed [Z_W-1:0]    zf;
  logic [THETA_W-1:0]       theta;
  logic [MAG_W-1:0]         mag;
  logic [DEG_W-1:0]         deg_mag;
  logic signed [DEG_W-1:0]  deg;

  assign fin = side_r[CORDIC_STEPS];
  assign zf  = z_r[CORDIC_STEPS];

  always_comb begin
    case (fin.code)
      cmps_pkg::THETA_ZERO:  theta = '0;
      cmps_pkg::THETA_RIGHT: theta = cmps_pkg::THETA_90;
      cmps_pkg::THETA_DIAG:  theta = cmps_pkg::THETA_45;
      default: begin
        // clamp the rotation result into 0..90 degrees
        if (zf[Z_W-1]) begin
          theta = '0;
        end else if (zf > Z_W'(cmps_pkg::THETA_90)) begin
          theta = cmps_pkg::THETA_90;
        end else begin
          theta = zf[THETA_W-1:0];
        end
      end
    endcase
  end

  assign mag     = fin.fx[FIELD_W-1] ? cmps_pkg::HALF_TURN - MAG_W'(theta)
                                     : MAG_W'(theta);
  assign deg_mag = DEG_W'(mag[MAG_W-1:cmps_pkg::ANGLE_FRAC]);
  assign deg     = fin.fy[FIELD_W-1] ? -$signed(deg_mag) : $signed(deg_mag);

  logic                      f1_v_r;
  logic signed [DEG_W-1:0]   f1_deg_r;
  logic signed [FIELD_W-1:0] f1_fx_r, f1_fy_r, f1_fz_r;
  logic                      f1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= v_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_deg_r <= deg;
      f1_fx_r  <= fin.fx;
      f1_fy_r  <= fin.fy;
      f1_fz_r  <= fin.fz;
      f1_ok_r  <= fin.ok;
    end
  end

  // ---------------- declination and wrap into the output register
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] wrapped;

  assign sum = {f1_deg_r[DEG_W-1], f1_deg_r}
             + {{(SUM_W-DECL_W){decl_r[DECL_W-1]}}, decl_r};

  always_comb begin
    if (sum < -cmps_pkg::FULL_TURN) begin
      wrapped = sum + (cmps_pkg::FULL_TURN <<< 1);
    end else if (sum < 0) begin
      wrapped = sum + cmps_pkg::FULL_TURN;
    end else if (sum > cmps_pkg::FULL_TURN) begin
      wrapped = sum - cmps_pkg::FULL_TURN;
    end else begin
      wrapped = sum;
    end
  end

  logic signed [FIELD_W-1:0] out_fx_r, out_fy_r, out_fz_r;
  logic [HEAD_W-1:0]         out_head_r;
  logic                      out_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= f1_v_r;
    end
  end

  // drop everything but the zero word for a failed sample
  always_ff @(posedge clk) begin
    if (adv) begin
      out_fx_r   <= f1_ok_r ? f1_fx_r : '0;
      out_fy_r   <= f1_ok_r ? f1_fy_r : '0;
      out_fz_r   <= f1_ok_r ? f1_fz_r : '0;
      out_head_r <= f1_ok_r ? wrapped[HEAD_W-1:0] : '0;
      out_ok_r   <= f1_ok_r;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.field_x     = out_fx_r;
  assign out_ch.field_y     = out_fy_r;
  assign out_ch.field_z     = out_fz_r;
  assign out_ch.heading_deg = out_head_r;
  assign out_ch.result_ok   = out_ok_r;

  // ---------------- assertions
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.heading_deg <= HEAD_W'(360))
    else $error("heading above a full turn");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.result_ok) |->
      (out_ch.field_x == '0 && out_ch.field_y == '0 && out_ch.field_z == '0 &&
       out_ch.heading_deg == '0))
    else $error("failed sample produced a nonzero word");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while the output is stalled");

  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    f1_v_r |-> (f1_deg_r >= -DEG_W'(180) && f1_deg_r <= DEG_W'(180)))
    else $error("folded angle outside half a turn");

endmodule

/* bench/tb.sv */
// Self-checking bench for compass_heading_from_field: offset-corrected field and heading.
// Depends on cmps_pkg, cmps_in_if, cmps_out_if and the block itself; an internal
// fixed-point atan2 predictor supplies every result word that is not written out below.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_W     = cmps_pkg::RAW_W;
  localparam int FIELD_W   = cmps_pkg::FIELD_W;
  localparam int HEAD_W    = cmps_pkg::HEAD_W;
  localparam int DECL_W    = cmps_pkg::DECL_W;
  localparam int CFG_IDX_W = cmps_pkg::CFG_IDX_W;

  localparam int ROTATIONS  = 24;
  localparam int PIPE_DEPTH = ROTATIONS + 4;
  localparam int Q16        = 16;
  localparam int N_DIRECTED = 20;
  localparam int N_PHASES   = 7;
  localparam int PHASE_LEN  = 64;

  // atan(2^-i) in degrees, Q16
  localparam longint ATAN_DEG_Q16 [0:ROTATIONS-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam longint EDGE_RAW [0:7] = '{
    -8388608, 8388607, 0, -1, 1, 8000000, -8000000, 4194304
  };

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    ok;
  } sample_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic [HEAD_W-1:0]         heading;
    logic                      ok;
  } heading_word_t;

  typedef struct packed {
    sample_t       s;
    logic          typed;
    heading_word_t want;
  } stim_row_t;

  // Fixed expectations where the heading is obvious; the rest use the predictor.
  localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b1, '{25'sd0, 25'sd0, 25'sd0, 9'd0, 1'b1}},
    '{'{24'sd1000, 24'sd0, 24'sd5, 1'b1}, 1'b1,
      '{25'sd1000, 25'sd0, 25'sd5, 9'd0, 1'b1}},
    '{'{24'sd0, 24'sd1000, 24'sd0, 1'b1}, 1'b1,
      '{25'sd0, 25'sd1000, 25'sd0, 9'd90, 1'b1}},
    '{'{-24'sd1000, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{-25'sd1000, 25'sd0, 25'sd0, 9'd180, 1'b1}},
    '{'{24'sd0, -24'sd1000, 24'sd0, 1'b1}, 1'b1,
      '{25'sd0, -25'sd1000, 25'sd0, 9'd270, 1'b1}},
    '{'{24'sd500, 24'sd500, 24'sd0, 1'b1}, 1'b1,
      '{25'sd500, 25'sd500, 25'sd0, 9'd45, 1'b1}},
    '{'{-24'sd500, 24'sd500, 24'sd0, 1'b1}, 1'b1,
      '{-25'sd500, 25'sd500, 25'sd0, 9'd135, 1'b1}},
    '{'{-24'sd500, -24'sd500, 24'sd0, 1'b1}, 1'b1,
      '{-25'sd500, -25'sd500, 25'sd0, 9'd225, 1'b1}},
    '{'{24'sd500, -24'sd500, 24'sd0, 1'b1}, 1'b1,
      '{25'sd500, -25'sd500, 25'sd0, 9'd315, 1'b1}},
    '{'{24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b1}, 1'b1,
      '{25'sd8388607, 25'sd8388607, 25'sd8388607, 9'd45, 1'b1}},
    '{'{24'sh800000, 24'sh800000, 24'sh800000, 1'b1}, 1'b1,
      '{-25'sd8388608, -25'sd8388608, -25'sd8388608, 9'd225, 1'b1}},
    '{'{24'sh800000, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{-25'sd8388608, 25'sd0, 25'sd0, 9'd180, 1'b1}},
    '{'{24'sd8388607, 24'sh800000, 24'sd1234, 1'b0}, 1'b1,
      '{25'sd0, 25'sd0, 25'sd0, 9'd0, 1'b0}},
    '{'{-24'sd8000000, 24'sd8000000, -24'sd1, 1'b1}, 1'b1,
      '{-25'sd8000000, 25'sd8000000, -25'sd1, 9'd135, 1'b1}},
    '{'{24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b1, '{25'sd0, 25'sd0, 25'sd0, 9'd0, 1'b0}},
    '{'{24'sd1, 24'sd2, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{24'sd1000000, 24'sd1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{-24'sd1000000, -24'sd1, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{24'sd3, -24'sd7, 24'sd9, 1'b1}, 1'b0, '0},
    '{'{24'sh800000, 24'sd8388607, -24'sd5, 1'b1}, 1'b0, '0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RAW_W-1:0]     cfg_data;

  cmps_in_if  in_ch ();
  cmps_out_if out_ch ();

  compass_heading_from_field #(.CORDIC_STEPS(ROTATIONS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the configuration registers
  logic signed [RAW_W-1:0]  off_x, off_y, off_z;
  logic signed [DECL_W-1:0] decl_deg;

  heading_word_t heading_q [$];
  int            mismatch_count = 0;
  bit            src_gaps_on    = 1'b1;
  bit            sink_stalls_on = 1'b1;
  int            sink_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  // First-quadrant angle of (ax, ay) in Q16 degrees by vectoring rotations
  function automatic longint quadrant_angle(input longint ax, input longint ay);
    longint x, y, z, xs, ys;
    if (ay == 0) return 0;
    if (ax == 0) return longint'(90) <<< Q16;
    if (ax == ay) return longint'(45) <<< Q16;
    x = ax <<< 30;
    y = ay <<< 30;
    z = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_DEG_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_DEG_Q16[i];
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) <<< Q16)) z = longint'(90) <<< Q16;
    return z;
  endfunction

  function automatic heading_word_t predict_heading(input sample_t s);
    heading_word_t r;
    longint fx, fy, fz, a, deg;
    r = '0;
    if (!s.ok) return r;
    fx = longint'($signed(s.raw_x)) + longint'(off_x);
    fy = longint'($signed(s.raw_y)) + longint'(off_y);
    fz = longint'($signed(s.raw_z)) + longint'(off_z);
    a = quadrant_angle(fx < 0 ? -fx : fx, fy < 0 ? -fy : fy);
    if (fx < 0) a = (longint'(180) <<< Q16) - a;
    if (fy < 0) a = -a;
    // truncate toward zero, then fold into 0..360
    deg = (a >= 0) ? (a >>> Q16) : -((-a) >>> Q16);
    deg = deg + longint'(decl_deg);
    while (deg < 0) deg = deg + 360;
    while (deg > 360) deg = deg - 360;
    r.field_x = FIELD_W'(fx);
    r.field_y = FIELD_W'(fy);
    r.field_z = FIELD_W'(fz);
    r.heading = HEAD_W'(deg);
    r.ok      = 1'b1;
    return r;
  endfunction

  function automatic longint signed_draw(input int unsigned span);
    return longint'($urandom_range(0, 2 * span)) - longint'(span);
  endfunction

  // Mostly aim at a corrected field of a given shape, so axes, diagonals and
  // small vectors near the origin show up under any offset.
  function automatic sample_t random_sample();
    sample_t s;
    longint  tx, ty, tz, m;
    int      kind;
    kind = $urandom_range(0, 9);
    tx = signed_draw(8000000);
    ty = signed_draw(8000000);
    tz = signed_draw(8000000);
    case (kind)
      1, 2: begin
        tx = signed_draw(2000);
        ty = signed_draw(2000);
        tz = signed_draw(2000);
      end
      3: begin
        if ($urandom_range(0, 1) == 1) tx = 0;
        else ty = 0;
      end
      4: begin
        m  = longint'($urandom_range(0, 4000000));
        tx = ($urandom_range(0, 1) == 1) ? m : -m;
        ty = ($urandom_range(0, 1) == 1) ? m : -m;
      end
      default: ;
    endcase
    s.raw_x = RAW_W'(tx - longint'(off_x));
    s.raw_y = RAW_W'(ty - longint'(off_y));
    s.raw_z = RAW_W'(tz - longint'(off_z));
    if (kind == 0) begin
      s.raw_x = RAW_W'($urandom);
      s.raw_y = RAW_W'($urandom);
      s.raw_z = RAW_W'($urandom);
    end else if (kind == 5) begin
      s.raw_x = RAW_W'(EDGE_RAW[$urandom_range(0, 7)]);
      s.raw_y = RAW_W'(EDGE_RAW[$urandom_range(0, 7)]);
      s.raw_z = RAW_W'(EDGE_RAW[$urandom_range(0, 7)]);
    end
    s.ok = ($urandom_range(0, 9) != 0);
    return s;
  endfunction

  // Offer one word, hold it until taken, then queue what it should produce
  task automatic send_sample(input sample_t s, input heading_word_t want);
    int gap;
    gap = (src_gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.raw_x     <= s.raw_x;
    in_ch.raw_y     <= s.raw_y;
    in_ch.raw_z     <= s.raw_z;
    in_ch.sample_ok <= s.ok;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    heading_q.push_back(want);
  endtask

  // Drop valid and wait until every queued result word has come back
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [RAW_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      cmps_pkg::CFG_OFFSET_X:    off_x    = data;
      cmps_pkg::CFG_OFFSET_Y:    off_y    = data;
      cmps_pkg::CFG_OFFSET_Z:    off_z    = data;
      cmps_pkg::CFG_DECLINATION: decl_deg = data[DECL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [RAW_W-1:0] ox, input logic [RAW_W-1:0] oy,
                                input logic [RAW_W-1:0] oz, input logic [DECL_W-1:0] decl);
    write_register(cmps_pkg::CFG_OFFSET_X, ox);
    write_register(cmps_pkg::CFG_OFFSET_Y, oy);
    write_register(cmps_pkg::CFG_OFFSET_Z, oz);
    // upper data bits are junk; only the low bits belong to the register
    write_register(cmps_pkg::CFG_DECLINATION, {(RAW_W-DECL_W)'($urandom), decl});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 19) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_word();
    heading_word_t want;
    if (heading_q.size() == 0) begin
      report_mismatch("result word with nothing expected");
      return;
    end
    want = heading_q.pop_front();
    if (out_ch.field_x !== want.field_x)
      report_mismatch($sformatf("field_x got %0d want %0d", out_ch.field_x, want.field_x));
    if (out_ch.field_y !== want.field_y)
      report_mismatch($sformatf("field_y got %0d want %0d", out_ch.field_y, want.field_y));
    if (out_ch.field_z !== want.field_z)
      report_mismatch($sformatf("field_z got %0d want %0d", out_ch.field_z, want.field_z));
    if (out_ch.heading_deg !== want.heading)
      report_mismatch($sformatf("heading_deg got %0d want %0d", out_ch.heading_deg,
                                want.heading));
    if (out_ch.result_ok !== want.ok)
      report_mismatch($sformatf("result_ok got %0b want %0b", out_ch.result_ok, want.ok));
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_word();
    end
  end

  initial begin
    sample_t s;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = cmps_pkg::CFG_OFFSET_X;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.raw_x     = '0;
    in_ch.raw_y     = '0;
    in_ch.raw_z     = '0;
    in_ch.sample_ok = 1'b0;
    off_x           = '0;
    off_y           = '0;
    off_z           = '0;
    decl_deg        = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: zero offsets, zero declination
    for (int r = 0; r < N_DIRECTED; r++) begin
      s = DIRECTED_ROWS[r].s;
      send_sample(s, DIRECTED_ROWS[r].typed ? DIRECTED_ROWS[r].want : predict_heading(s));
    end

    for (int p = 1; p <= N_PHASES; p++) begin
      drain_pipeline();
      case (p)
        1: apply_settings(24'sd12345, -24'sd54321, 24'sd777, 9'sd7);
        2: apply_settings(24'sd8388607, 24'sd8388607, 24'sd8388607, 9'sd255);
        3: apply_settings(24'sh800000, 24'sh800000, 24'sh800000, 9'sh100);
        4: apply_settings(24'sd8000000, -24'sd8000000, 24'sd0, 9'sd180);
        5: apply_settings(-24'sd8000000, 24'sd8000000, -24'sd1, -9'sd180);
        6: apply_settings(RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
                          DECL_W'($urandom));
        default: apply_settings('0, '0, '0, '0);
      endcase
      src_gaps_on    = (p != 2) && (p != 5) && (p != N_PHASES);
      sink_stalls_on = (p != 4) && (p != N_PHASES);
      // fill the pipeline against a blocked output
      if (p == 2) sink_hold_cycles = 150;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 4 && n == PHASE_LEN / 2) drain_pipeline();
        s = random_sample();
        send_sample(s, predict_heading(s));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 12) @(posedge clk);
    if (heading_q.size() != 0) report_mismatch("expected result words never arrived");
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
